/* rtl/utd_pkg.sv */
// shared types and constants for the utf-8 to utf-16 decoder
package utd_pkg;

   // result codes carried on the error field
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_LEAD  = 3'd1,
      ERR_BAD_TRAIL = 3'd2,
      ERR_SURROGATE = 3'd3,
      ERR_RANGE     = 3'd4,
      ERR_TRUNCATED = 3'd5
   } err_type;

   localparam int unsigned ACC_W       = 21;
   localparam logic [20:0] BMP_LIMIT   = 21'h010000;
   localparam logic [20:0] CODE_MAX    = 21'h10FFFF;
   localparam logic [20:0] SURR_FIRST  = 21'h00D800;
   localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
   localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;

   // one result item
   typedef struct packed {
      logic [15:0] code_unit;
      err_type     error_code;
      logic        last_of_run;
      logic        end_of_string;
   } rsp_type;

   // sequence state kept between bytes
   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic [1:0]       remain;
      logic             discard;
   } seq_type;

endpackage

/* rtl/utf8_to_utf16_decoder_core.sv */
// top level of the utf-8 to utf-16 decoder
//
// Takes one UTF-8 byte per item on the req_ channel, with req_string_end
// marking the last byte of a string, and returns UTF-16 code units on the
// rsp_ channel. Most bytes of a multi-byte sequence give no result; the
// byte that completes a sequence gives one code unit, or two items (high
// then low surrogate) for a code point above 0xFFFF. Errors give one item
// with code unit zero; the rest of that string is then dropped.
// An accepted byte waits in the input register, is decoded combinationally
// and is written into a two-entry result queue that drives the rsp_
// channel. Throughput: one byte per cycle while the queue has room, set by
// the single decode stage between the input register and the queue. Queue
// space counts the item taken this cycle, so req_ready follows rsp_ready
// combinationally and a receiver that is always ready never stalls the input,
// surrogate pairs included; a pair puts two items on the result channel.
// Reset clears the sequence state, the input register and the queue.
// When the receiver stalls, the queue fills and req_ready drops; nothing
// is lost and the byte stays in the input register.
module utf8_to_utf16_decoder_core
   import utd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_string_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_string
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       consume;
   logic [1:0] dec_count;
   rsp_type    dec_rsp0, dec_rsp1;
   seq_type    seq_state;
   rsp_type    head;
   logic       head_valid;
   logic [1:0] fill;
   logic [1:0] room;
   logic       pop;

   // space counts the item taken from the queue this cycle
   assign room      = 2'd2 - fill + {1'b0, pop};
   assign consume   = in_valid_ff && (dec_count <= room);
   assign req_ready = !in_valid_ff || consume;
   assign pop       = rsp_valid && rsp_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_string_end;
      end
   end

   utd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (in_byte_ff),
      .string_end (in_end_ff),
      .advance    (consume),
      .rsp_count  (dec_count),
      .rsp0       (dec_rsp0),
      .rsp1       (dec_rsp1),
      .seq_state  (seq_state)
   );

   utd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_count (consume ? dec_count : 2'd0),
      .push0      (dec_rsp0),
      .push1      (dec_rsp1),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .fill       (fill)
   );

   // result channel
   assign rsp_valid         = head_valid;
   assign rsp_code_unit     = head.code_unit;
   assign rsp_error_code    = head.error_code;
   assign rsp_last_of_run   = head.last_of_run;
   assign rsp_end_of_string = head.end_of_string;

   // queue never holds more than two items
   assert property (@(posedge clock) disable iff (reset) fill != 2'd3)
      else $error("result queue overfilled");

   // an item that does not end its run is always an error-free high surrogate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |->
         rsp_code_unit[15:10] == HIGH_SURR_TAG && rsp_error_code == ERR_NONE)
      else $error("non-final item is not a high surrogate");

   // error items carry a zero code unit and end their run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |->
         rsp_code_unit == 16'h0000 && rsp_last_of_run)
      else $error("malformed error item");

   // no pending trailing bytes while a failed string is dropped
   assert property (@(posedge clock) disable iff (reset)
      seq_state.discard |-> seq_state.remain == 2'd0)
      else $error("discarding with an open sequence");

endmodule

/* rtl/utd_decode.sv */
// byte decoder: sequence state registers and the per-byte decode logic
module utd_decode
   import utd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  in_byte,
   input  logic        string_end,
   input  logic        advance,
   output logic [1:0]  rsp_count,
   output rsp_type     rsp0,
   output rsp_type     rsp1,
   output seq_type     seq_state
);

   seq_type          seq_ff;
   seq_type          seq_in;
   logic [ACC_W-1:0] acc_ext;
   logic [ACC_W-1:0] offs;
   logic [1:0]       remain_dec;

   assign seq_state  = seq_ff;
   assign acc_ext    = {seq_ff.acc[ACC_W-7:0], in_byte[5:0]};
   assign offs       = acc_ext - BMP_LIMIT;
   assign remain_dec = seq_ff.remain - 2'd1;

   // error item; callers clear the sequence, drop bytes unless it is the end byte
   function automatic rsp_type err_rsp(input err_type code, input logic eos);
      rsp_type r;
      r.code_unit     = 16'h0000;
      r.error_code    = code;
      r.last_of_run   = 1'b1;
      r.end_of_string = eos;
      return r;
   endfunction

   // decode one byte against the current state
   always_comb begin
      seq_in    = seq_ff;
      rsp_count = 2'd0;
      rsp0      = '0;
      rsp1      = '0;
      if (seq_ff.discard) begin
         if (string_end) begin
            seq_in.discard = 1'b0;
         end
      end else if (seq_ff.remain == 2'd0) begin
         if (!in_byte[7]) begin
            rsp_count          = 2'd1;
            rsp0.code_unit     = {8'h00, in_byte};
            rsp0.error_code    = ERR_NONE;
            rsp0.last_of_run   = 1'b1;
            rsp0.end_of_string = string_end;
         end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                      in_byte[7:3] == 5'b11110) begin
            // lead byte of a multi-byte sequence
            if (string_end) begin
               rsp_count = 2'd1;
               rsp0      = err_rsp(ERR_TRUNCATED, 1'b1);
               seq_in    = '0;
            end else if (in_byte[7:5] == 3'b110) begin
               seq_in.acc    = {16'h0000, in_byte[4:0]};
               seq_in.remain = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
               seq_in.acc    = {17'h00000, in_byte[3:0]};
               seq_in.remain = 2'd2;
            end else begin
               seq_in.acc    = {18'h00000, in_byte[2:0]};
               seq_in.remain = 2'd3;
            end
         end else begin
            rsp_count      = 2'd1;
            rsp0           = err_rsp(ERR_BAD_LEAD, string_end);
            seq_in         = '0;
            seq_in.discard = !string_end;
         end
      end else if (in_byte[7:6] != 2'b10) begin
         rsp_count      = 2'd1;
         rsp0           = err_rsp(ERR_BAD_TRAIL, string_end);
         seq_in         = '0;
         seq_in.discard = !string_end;
      end else if (remain_dec != 2'd0) begin
         // more trailing bytes to come
         if (string_end) begin
            rsp_count = 2'd1;
            rsp0      = err_rsp(ERR_TRUNCATED, 1'b1);
            seq_in    = '0;
         end else begin
            seq_in.acc    = acc_ext;
            seq_in.remain = remain_dec;
         end
      end else begin
         // sequence complete
         seq_in    = '0;
         rsp_count = 2'd1;
         if (acc_ext < BMP_LIMIT) begin
            if (acc_ext >= SURR_FIRST && acc_ext <= SURR_LAST) begin
               rsp0           = err_rsp(ERR_SURROGATE, string_end);
               seq_in.discard = !string_end;
            end else begin
               rsp0.code_unit     = acc_ext[15:0];
               rsp0.error_code    = ERR_NONE;
               rsp0.last_of_run   = 1'b1;
               rsp0.end_of_string = string_end;
            end
         end else if (acc_ext > CODE_MAX) begin
            rsp0           = err_rsp(ERR_RANGE, string_end);
            seq_in.discard = !string_end;
         end else begin
            rsp_count          = 2'd2;
            rsp0.code_unit     = {HIGH_SURR_TAG, offs[19:10]};
            rsp0.error_code    = ERR_NONE;
            rsp0.last_of_run   = 1'b0;
            rsp0.end_of_string = 1'b0;
            rsp1.code_unit     = {LOW_SURR_TAG, offs[9:0]};
            rsp1.error_code    = ERR_NONE;
            rsp1.last_of_run   = 1'b1;
            rsp1.end_of_string = string_end;
         end
      end
   end

   // state update on each consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else if (advance) begin
         seq_ff <= seq_in;
      end
   end

endmodule

/* rtl/utd_out_buf.sv */
// two-entry result queue in front of the result channel
module utd_out_buf
   import utd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  rsp_type    push0,
   input  rsp_type    push1,
   input  logic       pop,
   output rsp_type    head,
   output logic       head_valid,
   output logic [1:0] fill
);

   rsp_type    q0_ff, q1_ff, q0_in, q1_in;
   logic [1:0] cnt_ff, cnt_in, rem_cnt;
   rsp_type    rem0;

   assign head       = q0_ff;
   assign head_valid = (cnt_ff != 2'd0);
   assign fill       = cnt_ff;

   // drop the head, then append new results behind what is left
   always_comb begin
      rem_cnt = cnt_ff - {1'b0, pop};
      rem0    = pop ? q1_ff : q0_ff;
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      case (rem_cnt)
         2'd0: begin
            q0_in = push0;
            q1_in = push1;
         end
         2'd1: begin
            q0_in = rem0;
            q1_in = push0;
         end
         default: begin
            q0_in = q0_ff;
            q1_in = q1_ff;
         end
      endcase
      cnt_in = rem_cnt + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

endmodule
